// ----- design/qvr_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and width helpers for the quaternion vector rotation
// no dependencies; used by every other file of the block

package qvr_pkg;

  // quaternion components are signed Q1.14 in 16 bits
  localparam int QUAT_WIDTH = 16;

  // parameter defaults
  localparam int DEF_VEC_WIDTH = 16;
  localparam int DEF_FRAC_BITS = 14;

  typedef logic signed [QUAT_WIDTH-1:0] quat_t;

  // width of one component of q * (0, v): product plus two bits of sum growth
  function automatic int left_width(input int vec_width);
    left_width = vec_width + QUAT_WIDTH + 2;
  endfunction

  // width of one component of the second product, with room for the rounding
  // offset and always at least two bits above the output shift
  function automatic int sum_width(input int vec_width, input int frac_bits);
    int raw;
    raw = left_width(vec_width) + QUAT_WIDTH + 3;
    sum_width = (raw > 2 * frac_bits + 1) ? raw : 2 * frac_bits + 2;
  endfunction

endpackage

// ----- design/qvr_left.sv -----
`timescale 1ns / 1ps
// first hamilton product t = q * (0, v), kept at full precision
// two stages: twelve products, then four sums; uses qvr_pkg

module qvr_left #(
  parameter int VEC_WIDTH = qvr_pkg::DEF_VEC_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [VEC_WIDTH-1:0] vec_i [3],
  input  qvr_pkg::quat_t              quat_i [4],
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [qvr_pkg::left_width(VEC_WIDTH)-1:0] t_o [4],
  output qvr_pkg::quat_t              quat_o [4]
);

  localparam int PW = VEC_WIDTH + qvr_pkg::QUAT_WIDTH;
  localparam int TW = qvr_pkg::left_width(VEC_WIDTH);

  logic                 a_valid_r;
  logic signed [PW-1:0] a_prod_r   [12];
  logic signed [PW-1:0] a_prod_nxt [12];
  qvr_pkg::quat_t       a_quat_r   [4];
  logic                 b_valid_r;
  logic signed [TW-1:0] b_t_r      [4];
  logic signed [TW-1:0] b_t_nxt    [4];
  qvr_pkg::quat_t       b_quat_r   [4];
  logic                 a_ready;
  logic                 b_ready;

  function automatic logic signed [PW-1:0] mul(input logic signed [VEC_WIDTH-1:0] a,
                                               input qvr_pkg::quat_t b);
    mul = PW'(a) * PW'(b);
  endfunction

  // a stage moves when empty or when the next one moves
  assign b_ready    = !b_valid_r || out_ready_i;
  assign a_ready    = !a_valid_r || b_ready;
  assign in_ready_o = a_ready;

  // products, v = (0, x, y, z), q = (w, i, j, k)
  always_comb begin
    a_prod_nxt[0]  = mul(vec_i[0], quat_i[0]);
    a_prod_nxt[1]  = mul(vec_i[2], quat_i[2]);
    a_prod_nxt[2]  = mul(vec_i[1], quat_i[3]);
    a_prod_nxt[3]  = mul(vec_i[1], quat_i[0]);
    a_prod_nxt[4]  = mul(vec_i[2], quat_i[1]);
    a_prod_nxt[5]  = mul(vec_i[0], quat_i[3]);
    a_prod_nxt[6]  = mul(vec_i[2], quat_i[0]);
    a_prod_nxt[7]  = mul(vec_i[1], quat_i[1]);
    a_prod_nxt[8]  = mul(vec_i[0], quat_i[2]);
    a_prod_nxt[9]  = mul(vec_i[0], quat_i[1]);
    a_prod_nxt[10] = mul(vec_i[1], quat_i[2]);
    a_prod_nxt[11] = mul(vec_i[2], quat_i[3]);
  end

  // component sums of q * (0, v)
  always_comb begin
    b_t_nxt[0] = -TW'(a_prod_r[9]) - TW'(a_prod_r[10]) - TW'(a_prod_r[11]);
    b_t_nxt[1] =  TW'(a_prod_r[0]) + TW'(a_prod_r[1])  - TW'(a_prod_r[2]);
    b_t_nxt[2] =  TW'(a_prod_r[3]) - TW'(a_prod_r[4])  + TW'(a_prod_r[5]);
    b_t_nxt[3] =  TW'(a_prod_r[6]) + TW'(a_prod_r[7])  - TW'(a_prod_r[8]);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_valid_i;
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  // payload, loaded only on a transfer into the stage
  always_ff @(posedge clk) begin
    if (a_ready && in_valid_i) begin
      a_prod_r <= a_prod_nxt;
      a_quat_r <= quat_i;
    end
    if (b_ready && a_valid_r) begin
      b_t_r    <= b_t_nxt;
      b_quat_r <= a_quat_r;
    end
  end

  assign out_valid_o = b_valid_r;
  assign t_o         = b_t_r;
  assign quat_o      = b_quat_r;

endmodule

// ----- design/qvr_right.sv -----
`timescale 1ns / 1ps
// second hamilton product r = t * conj(q), imaginary parts only, plus rounding offset
// two stages: twelve products, then three sums; uses qvr_pkg

module qvr_right #(
  parameter int VEC_WIDTH = qvr_pkg::DEF_VEC_WIDTH,
  parameter int FRAC_BITS = qvr_pkg::DEF_FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic signed [qvr_pkg::left_width(VEC_WIDTH)-1:0] t_i [4],
  input  qvr_pkg::quat_t quat_i [4],
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic signed [qvr_pkg::sum_width(VEC_WIDTH, FRAC_BITS)-1:0] r_o [3]
);

  localparam int TW        = qvr_pkg::left_width(VEC_WIDTH);
  localparam int PW        = TW + qvr_pkg::QUAT_WIDTH;
  localparam int RW        = qvr_pkg::sum_width(VEC_WIDTH, FRAC_BITS);
  localparam int OUT_SHIFT = 2 * FRAC_BITS;
  // one half of the output lsb
  localparam logic signed [RW-1:0] ROUND_HALF =
    {{(RW-OUT_SHIFT){1'b0}}, 1'b1, {(OUT_SHIFT-1){1'b0}}};

  logic                 c_valid_r;
  logic signed [PW-1:0] c_prod_r   [12];
  logic signed [PW-1:0] c_prod_nxt [12];
  logic                 d_valid_r;
  logic signed [RW-1:0] d_r_r      [3];
  logic signed [RW-1:0] d_r_nxt    [3];
  logic                 c_ready;
  logic                 d_ready;

  function automatic logic signed [PW-1:0] mul(input logic signed [TW-1:0] a,
                                               input qvr_pkg::quat_t b);
    mul = PW'(a) * PW'(b);
  endfunction

  assign d_ready    = !d_valid_r || out_ready_i;
  assign c_ready    = !c_valid_r || d_ready;
  assign in_ready_o = c_ready;

  // products t_a * q_b; conjugate signs are applied in the sums
  always_comb begin
    c_prod_nxt[0]  = mul(t_i[0], quat_i[1]);
    c_prod_nxt[1]  = mul(t_i[1], quat_i[0]);
    c_prod_nxt[2]  = mul(t_i[2], quat_i[3]);
    c_prod_nxt[3]  = mul(t_i[3], quat_i[2]);
    c_prod_nxt[4]  = mul(t_i[0], quat_i[2]);
    c_prod_nxt[5]  = mul(t_i[1], quat_i[3]);
    c_prod_nxt[6]  = mul(t_i[2], quat_i[0]);
    c_prod_nxt[7]  = mul(t_i[3], quat_i[1]);
    c_prod_nxt[8]  = mul(t_i[0], quat_i[3]);
    c_prod_nxt[9]  = mul(t_i[1], quat_i[2]);
    c_prod_nxt[10] = mul(t_i[2], quat_i[1]);
    c_prod_nxt[11] = mul(t_i[3], quat_i[0]);
  end

  // imaginary sums with the rounding half folded in
  always_comb begin
    d_r_nxt[0] = -RW'(c_prod_r[0]) + RW'(c_prod_r[1]) - RW'(c_prod_r[2])
                 + RW'(c_prod_r[3]) + ROUND_HALF;
    d_r_nxt[1] = -RW'(c_prod_r[4]) + RW'(c_prod_r[5]) + RW'(c_prod_r[6])
                 - RW'(c_prod_r[7]) + ROUND_HALF;
    d_r_nxt[2] = -RW'(c_prod_r[8]) - RW'(c_prod_r[9]) + RW'(c_prod_r[10])
                 + RW'(c_prod_r[11]) + ROUND_HALF;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      if (c_ready) c_valid_r <= in_valid_i;
      if (d_ready) d_valid_r <= c_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (c_ready && in_valid_i) c_prod_r <= c_prod_nxt;
    if (d_ready && c_valid_r)  d_r_r    <= d_r_nxt;
  end

  assign out_valid_o = d_valid_r;
  assign r_o         = d_r_r;

endmodule

// ----- design/qvr_scale_sat.sv -----
`timescale 1ns / 1ps
// output stage: shift back to vector units (floor after the rounding offset),
// saturate to the vector width and flag clipping; uses qvr_pkg

module qvr_scale_sat #(
  parameter int VEC_WIDTH = qvr_pkg::DEF_VEC_WIDTH,
  parameter int FRAC_BITS = qvr_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [qvr_pkg::sum_width(VEC_WIDTH, FRAC_BITS)-1:0] r_i [3],
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [VEC_WIDTH-1:0] rot_o [3],
  output logic                        clipped_o
);

  localparam int RW        = qvr_pkg::sum_width(VEC_WIDTH, FRAC_BITS);
  localparam int OUT_SHIFT = 2 * FRAC_BITS;
  localparam logic signed [RW-1:0] SAT_HI =
    {{(RW-VEC_WIDTH+1){1'b0}}, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  logic                        e_valid_r;
  logic signed [VEC_WIDTH-1:0] e_rot_r   [3];
  logic signed [VEC_WIDTH-1:0] e_rot_nxt [3];
  logic                        e_clip_r;
  logic                        e_clip_nxt;
  logic signed [RW-1:0]        shifted   [3];
  logic                        e_ready;

  assign e_ready    = !e_valid_r || out_ready_i;
  assign in_ready_o = e_ready;

  // arithmetic shift is the floor; compare against the rails
  always_comb begin
    e_clip_nxt = 1'b0;
    for (int n = 0; n < 3; n++) begin
      shifted[n] = r_i[n] >>> OUT_SHIFT;
      if (shifted[n] > SAT_HI) begin
        e_rot_nxt[n] = SAT_HI[VEC_WIDTH-1:0];
        e_clip_nxt   = 1'b1;
      end else if (shifted[n] < SAT_LO) begin
        e_rot_nxt[n] = SAT_LO[VEC_WIDTH-1:0];
        e_clip_nxt   = 1'b1;
      end else begin
        e_rot_nxt[n] = shifted[n][VEC_WIDTH-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (e_ready) begin
      e_valid_r <= in_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && in_valid_i) begin
      e_rot_r  <= e_rot_nxt;
      e_clip_r <= e_clip_nxt;
    end
  end

  assign out_valid_o = e_valid_r;
  assign rot_o       = e_rot_r;
  assign clipped_o   = e_clip_r;

endmodule

// ----- design/quaternion_vector_rotation.sv -----
`timescale 1ns / 1ps
// Quaternion vector rotation, top level: rotates v by q as q * (0, v) * conj(q).
// Input channel: in_valid / in_stall with vector x, y, z (VEC_WIDTH bits, signed)
// and quaternion w, i, j, k (signed Q1.14, 16384 is one). A transfer happens at a
// rising edge with valid high and stall low.
// Result channel: out_valid / out_stall with rot_x, rot_y, rot_z (saturated to
// VEC_WIDTH bits) and clipped, set when any component hit a rail. The first
// product is exact; the second is rounded half up at 2*FRAC_BITS and saturated.
// Five register stages: twelve multipliers, sum, twelve multipliers, sum,
// shift/saturate. The first stage loads at the input transfer edge, and out_valid
// rises once the item reaches the shift/saturate register. Throughput is one
// rotation per cycle while the receiver does not stall; items are independent.
// Every stage has its own valid bit and advances when it is empty or the stage
// after it advances, so bubbles are squeezed out and a stalled receiver only
// blocks input once all five stages hold items; the output register holds its
// payload while out_stall is high.
// Synchronous active-low reset empties the pipeline; payload is not cleared.

module quaternion_vector_rotation #(
  parameter int VEC_WIDTH = qvr_pkg::DEF_VEC_WIDTH,
  parameter int FRAC_BITS = qvr_pkg::DEF_FRAC_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [VEC_WIDTH-1:0]               in_vec_x,
  input  logic signed [VEC_WIDTH-1:0]               in_vec_y,
  input  logic signed [VEC_WIDTH-1:0]               in_vec_z,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]     in_quat_w,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]     in_quat_i,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]     in_quat_j,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]     in_quat_k,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [VEC_WIDTH-1:0]               out_rot_x,
  output logic signed [VEC_WIDTH-1:0]               out_rot_y,
  output logic signed [VEC_WIDTH-1:0]               out_rot_z,
  output logic                                      out_clipped
);

  localparam int TW = qvr_pkg::left_width(VEC_WIDTH);
  localparam int RW = qvr_pkg::sum_width(VEC_WIDTH, FRAC_BITS);

  logic signed [VEC_WIDTH-1:0] vec   [3];
  qvr_pkg::quat_t              quat  [4];
  logic                        left_ready;
  logic                        left_valid;
  logic signed [TW-1:0]        t_comp [4];
  qvr_pkg::quat_t              t_quat [4];
  logic                        right_ready;
  logic                        right_valid;
  logic signed [RW-1:0]        r_comp [3];
  logic                        sat_ready;
  logic signed [VEC_WIDTH-1:0] rot   [3];

  // input bundling
  assign vec[0]  = in_vec_x;
  assign vec[1]  = in_vec_y;
  assign vec[2]  = in_vec_z;
  assign quat[0] = in_quat_w;
  assign quat[1] = in_quat_i;
  assign quat[2] = in_quat_j;
  assign quat[3] = in_quat_k;

  assign in_stall = !left_ready;

  // q * (0, v)
  qvr_left #(
    .VEC_WIDTH (VEC_WIDTH)
  ) u_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (left_ready),
    .vec_i       (vec),
    .quat_i      (quat),
    .out_valid_o (left_valid),
    .out_ready_i (right_ready),
    .t_o         (t_comp),
    .quat_o      (t_quat)
  );

  // t * conj(q)
  qvr_right #(
    .VEC_WIDTH (VEC_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (left_valid),
    .in_ready_o  (right_ready),
    .t_i         (t_comp),
    .quat_i      (t_quat),
    .out_valid_o (right_valid),
    .out_ready_i (sat_ready),
    .r_o         (r_comp)
  );

  // rescale, saturate, output register
  qvr_scale_sat #(
    .VEC_WIDTH (VEC_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_scale_sat (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (right_valid),
    .in_ready_o  (sat_ready),
    .r_i         (r_comp),
    .out_valid_o (out_valid),
    .out_ready_i (!out_stall),
    .rot_o       (rot),
    .clipped_o   (out_clipped)
  );

  assign out_rot_x = rot[0];
  assign out_rot_y = rot[1];
  assign out_rot_z = rot[2];

endmodule

// ----- design/qvr_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for quaternion_vector_rotation, attached with bind
// depends on qvr_pkg and the top level's port list

module qvr_checker #(
  parameter int VEC_WIDTH = qvr_pkg::DEF_VEC_WIDTH
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [VEC_WIDTH-1:0]           out_rot_x,
  input logic signed [VEC_WIDTH-1:0]           out_rot_y,
  input logic signed [VEC_WIDTH-1:0]           out_rot_z,
  input logic                                  out_clipped
);

  localparam logic signed [VEC_WIDTH-1:0] RAIL_HI = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] RAIL_LO = ~RAIL_HI;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_rot_x) && $stable(out_rot_y)
      && $stable(out_rot_z) && $stable(out_clipped))
    else $error("result payload changed while stalled");

  // a clipped result has at least one component on a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_rot_x == RAIL_HI) || (out_rot_x == RAIL_LO) ||
      (out_rot_y == RAIL_HI) || (out_rot_y == RAIL_LO) ||
      (out_rot_z == RAIL_HI) || (out_rot_z == RAIL_LO))
    else $error("clipped set with no component saturated");

endmodule

bind quaternion_vector_rotation qvr_checker #(
  .VEC_WIDTH (VEC_WIDTH)
) u_qvr_checker (.*);
